// File: design/positional_insert_erase_list_macros.svh
// Assertion macros for the positional insert and erase list.
// Used by the port checker; depends on nothing else.
`ifndef POSITIONAL_INSERT_ERASE_LIST_MACROS_SVH
`define POSITIONAL_INSERT_ERASE_LIST_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PIE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PIE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/pie_pkg.sv
// Shared types, constants and codes for the positional insert and erase list.
// Used by every module of the block; depends on nothing else.
package pie_pkg;

	localparam int DEPTH      = 64;
	localparam int WORD_WIDTH = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int POS_W      = $clog2(DEPTH);

	typedef logic [WORD_WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [POS_W-1:0]      pos_t;

	typedef enum logic [2:0] {
		REQ_APPEND      = 3'd0,
		REQ_REMOVE_LAST = 3'd1,
		REQ_INSERT      = 3'd2,
		REQ_ERASE_ONE   = 3'd3,
		REQ_ERASE_RANGE = 3'd4,
		REQ_READ        = 3'd5,
		REQ_WRITE       = 3'd6
	} req_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		CELL_HOLD     = 2'd0,
		CELL_LOAD     = 2'd1,
		CELL_INSERT   = 2'd2,
		CELL_SHIFT_DN = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		cnt_t     pos;
		word_t    data;
	} cell_cmd_t;

endpackage

// File: design/pie_cell.sv
// One storage cell of the list chain: holds a single element.
// Depends on pie_pkg for the command structure and word type.
module pie_cell import pie_pkg::*; (
	input  logic      clk,
	input  cnt_t      idx,
	input  cell_cmd_t cmd,
	input  word_t     left_word,
	input  word_t     right_word,
	output word_t     word
);

	word_t word_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_LOAD: begin
				if (idx == cmd.pos) begin
					word_q <= cmd.data;
				end
			end
			CELL_INSERT: begin
				if (idx == cmd.pos) begin
					word_q <= cmd.data;
				end else if (idx > cmd.pos) begin
					word_q <= left_word;
				end
			end
			CELL_SHIFT_DN: begin
				if (idx >= cmd.pos) begin
					word_q <= right_word;
				end
			end
			default: begin
				word_q <= word_q;
			end
		endcase
	end

	assign word = word_q;

endmodule

// File: design/pie_ctrl.sv
// Request decoder and sequencer of the list: checks each request, drives the
// cell chain and forms the result. Depends on pie_pkg.
module pie_ctrl import pie_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] req_type,
	input  logic [6:0] position,
	input  logic [6:0] range_end,
	input  logic [31:0] data_word,
	input  word_t      rd_word,
	output pos_t       rd_idx,
	output cell_cmd_t  cmd,
	output logic       busy,
	output logic       done,
	output word_t      res_word,
	output cnt_t       count,
	output stat_t      res_stat
);

	typedef enum logic [1:0] {
		FSM_IDLE  = 2'b01,
		FSM_SHIFT = 2'b10
	} fsm_t;

	fsm_t  state_q;
	cnt_t  count_q;
	cnt_t  rem_q;
	cnt_t  pos_q;
	logic  done_q;
	word_t rd_q;
	stat_t stat_q;

	logic  accept;
	cnt_t  pos;
	cnt_t  fin;
	cnt_t  span;
	word_t data;

	cell_cmd_t acc_cmd;
	stat_t     acc_stat;
	cnt_t      acc_count;
	word_t     acc_rd;
	logic      acc_multi;

	assign accept = start && (state_q == FSM_IDLE);
	assign pos    = CNT_W'(position);
	assign fin    = CNT_W'(range_end);
	assign span   = fin - pos;
	assign data   = WORD_WIDTH'(data_word);
	assign rd_idx = POS_W'(pos);

	always_comb begin
		acc_cmd.op   = CELL_HOLD;
		acc_cmd.pos  = pos;
		acc_cmd.data = data;
		acc_stat     = STAT_DONE;
		acc_count    = count_q;
		acc_rd       = '0;
		acc_multi    = 1'b0;
		case (req_t'(req_type))
			REQ_APPEND: begin
				if (count_q >= CNT_W'(DEPTH)) begin
					acc_stat = STAT_FULL;
				end else begin
					acc_cmd.op  = CELL_LOAD;
					acc_cmd.pos = count_q;
					acc_count   = count_q + 1'b1;
				end
			end
			REQ_REMOVE_LAST: begin
				if (count_q == '0) begin
					acc_stat = STAT_RANGE;
				end else begin
					acc_count = count_q - 1'b1;
				end
			end
			REQ_INSERT: begin
				if (pos > count_q) begin
					acc_stat = STAT_RANGE;
				end else if (count_q >= CNT_W'(DEPTH)) begin
					acc_stat = STAT_FULL;
				end else begin
					acc_cmd.op = CELL_INSERT;
					acc_count  = count_q + 1'b1;
				end
			end
			REQ_ERASE_ONE: begin
				if (pos >= count_q) begin
					acc_stat = STAT_RANGE;
				end else begin
					acc_cmd.op = CELL_SHIFT_DN;
					acc_count  = count_q - 1'b1;
				end
			end
			REQ_ERASE_RANGE: begin
				if ((pos > fin) || (fin > count_q)) begin
					acc_stat = STAT_RANGE;
				end else if (span != '0) begin
					acc_cmd.op = CELL_SHIFT_DN;
					acc_count  = count_q - span;
					acc_multi  = (span > CNT_W'(1));
				end
			end
			REQ_READ: begin
				if (pos >= count_q) begin
					acc_stat = STAT_RANGE;
				end else begin
					acc_rd = rd_word;
				end
			end
			REQ_WRITE: begin
				if (pos >= count_q) begin
					acc_stat = STAT_RANGE;
				end else begin
					acc_cmd.op = CELL_LOAD;
				end
			end
			default: begin
				acc_stat = STAT_DONE;
			end
		endcase
	end

	always_comb begin
		cmd.op   = CELL_HOLD;
		cmd.pos  = pos_q;
		cmd.data = data;
		if (state_q == FSM_SHIFT) begin
			cmd.op = CELL_SHIFT_DN;
		end else if (accept) begin
			cmd = acc_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			count_q <= '0;
			rem_q   <= '0;
			pos_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				FSM_IDLE: begin
					if (accept) begin
						count_q <= acc_count;
						pos_q   <= pos;
						rem_q   <= span - 1'b1;
						if (acc_multi) begin
							state_q <= FSM_SHIFT;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				FSM_SHIFT: begin
					rem_q <= rem_q - 1'b1;
					if (rem_q == CNT_W'(1)) begin
						done_q  <= 1'b1;
						state_q <= FSM_IDLE;
					end
				end
				default: begin
					state_q <= FSM_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q   <= acc_rd;
			stat_q <= acc_stat;
		end
	end

	assign busy     = (state_q == FSM_SHIFT);
	assign done     = done_q;
	assign res_word = rd_q;
	assign count    = count_q;
	assign res_stat = stat_q;

endmodule

// File: design/positional_insert_erase_list.sv
// Top level of the positional insert and erase list: a chain of storage
// cells driven by one sequencer. Depends on pie_pkg, pie_cell and pie_ctrl.
//
// A request is taken when start is high and busy is low. Its result appears
// on read_word, element_count, is_empty and status, marked by done, which is
// high for a single cycle in the cycle after the request completes; the
// receiver cannot stall it. An erase of a range of more than one element
// moves the tail down in steps, because the cell chain moves it by one place
// per cycle; busy is high while the steps after the first run. Every other
// request completes when it is taken. A new request may be taken in the same
// cycle in which the previous result is shown. The element store has no
// reset; only elements below the count are ever read.
module positional_insert_erase_list import pie_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [6:0]  position,
	input  logic [6:0]  range_end,
	input  logic [31:0] data_word,
	output logic        done,
	output logic [31:0] read_word,
	output logic [6:0]  element_count,
	output logic        is_empty,
	output logic [1:0]  status
);

	word_t     words [DEPTH];
	cell_cmd_t cmd;
	pos_t      rd_idx;
	word_t     res_word;
	cnt_t      count;
	stat_t     res_stat;

	pie_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req_type  (req_type),
		.position  (position),
		.range_end (range_end),
		.data_word (data_word),
		.rd_word   (words[rd_idx]),
		.rd_idx    (rd_idx),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.res_word  (res_word),
		.count     (count),
		.res_stat  (res_stat)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t left_word;
		word_t right_word;

		if (i == 0) begin : g_first
			assign left_word = words[i];
		end else begin : g_left
			assign left_word = words[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_word = words[i];
		end else begin : g_right
			assign right_word = words[i+1];
		end

		pie_cell u_cell (
			.clk        (clk),
			.idx        (CNT_W'(i)),
			.cmd        (cmd),
			.left_word  (left_word),
			.right_word (right_word),
			.word       (words[i])
		);
	end

	assign read_word     = 32'(res_word);
	assign element_count = 7'(count);
	assign is_empty      = (count == '0);
	assign status        = res_stat;

endmodule

// File: design/pie_checker.sv
// Port-level checker for the positional insert and erase list, with its bind.
// Depends on pie_pkg and positional_insert_erase_list_macros.svh.
`include "positional_insert_erase_list_macros.svh"

module pie_checker import pie_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [2:0]  req_type,
	input logic        done,
	input logic [31:0] read_word,
	input logic [6:0]  element_count,
	input logic        is_empty,
	input logic [1:0]  status
);

	logic flag_ok;
	logic refused;
	logic one_cycle_req;

	assign flag_ok       = (is_empty == (element_count == 7'd0));
	assign refused       = done && (status != STAT_DONE);
	assign one_cycle_req = start && !busy && (req_type != REQ_ERASE_RANGE);

	`PIE_ASSERT_NOW(a_empty_flag, clk, arst_n, done, flag_ok, "is_empty disagrees with count")
	`PIE_ASSERT_NOW(a_fail_zero, clk, arst_n, refused, read_word == 32'd0, "refusal gave data")
	`PIE_ASSERT_NEXT(a_single_cycle, clk, arst_n, one_cycle_req, done, "no result transfer")
	`PIE_ASSERT_NOW(a_shift_end, clk, arst_n, $fell(busy), done, "range erase gave no result")

endmodule

bind positional_insert_erase_list pie_checker u_pie_checker (.*);

// File: verif/tb_positional_insert_erase_list.sv
// Self-checking testbench for positional_insert_erase_list: directed edge cases, then random
// traffic with sender gaps, all checked against a behavioural copy of the list.
// Depends on pie_pkg and the positional_insert_erase_list RTL.
`timescale 1ns / 100ps

module tb_positional_insert_erase_list;
	import pie_pkg::*;

	localparam logic [2:0] REQ_UNUSED = 3'd7;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = DEPTH + 8;
	localparam int MIX_GROW     = 0;
	localparam int MIX_SHRINK   = 1;
	localparam int MIX_EVEN     = 2;

	typedef struct packed {
		word_t      word;
		logic [6:0] count;
		logic       empty;
		stat_t      stat;
	} list_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  req_type;
	logic [6:0]  position;
	logic [6:0]  range_end;
	logic [31:0] data_word;
	logic        done;
	logic [31:0] read_word;
	logic [6:0]  element_count;
	logic        is_empty;
	logic [1:0]  status;

	word_t        shadow_list [DEPTH];
	int           shadow_count;
	list_result_t pending_results [$];
	int           mismatch_count;
	int           results_seen;
	int           stall_cycles;
	int           sender_idle_pct;
	int           req_tally [8];
	int           full_tally;
	int           range_tally;

	positional_insert_erase_list dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.position(position),
		.range_end(range_end),
		.data_word(data_word),
		.done(done),
		.read_word(read_word),
		.element_count(element_count),
		.is_empty(is_empty),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic list_result_t apply_request(input logic [2:0] req, input logic [6:0] pos,
		input logic [6:0] lim, input word_t data);
		list_result_t r;
		int n;
		int p;
		int e;
		int i;
		n = shadow_count;
		p = pos;
		e = lim;
		r.word = '0;
		r.stat = STAT_DONE;
		case (req)
			REQ_APPEND: begin
				if (n >= DEPTH) begin
					r.stat = STAT_FULL;
				end else begin
					shadow_list[n] = data;
					shadow_count = n + 1;
				end
			end
			REQ_REMOVE_LAST: begin
				if (n == 0) r.stat = STAT_RANGE;
				else shadow_count = n - 1;
			end
			REQ_INSERT: begin
				if (p > n) begin
					r.stat = STAT_RANGE;
				end else if (n >= DEPTH) begin
					r.stat = STAT_FULL;
				end else begin
					for (i = n; i > p; i--) shadow_list[i] = shadow_list[i - 1];
					shadow_list[p] = data;
					shadow_count = n + 1;
				end
			end
			REQ_ERASE_ONE: begin
				if (p >= n) begin
					r.stat = STAT_RANGE;
				end else begin
					for (i = p; i + 1 < n; i++) shadow_list[i] = shadow_list[i + 1];
					shadow_count = n - 1;
				end
			end
			REQ_ERASE_RANGE: begin
				if (p > e || e > n) begin
					r.stat = STAT_RANGE;
				end else begin
					for (i = 0; e + i < n; i++) shadow_list[p + i] = shadow_list[e + i];
					shadow_count = n - (e - p);
				end
			end
			REQ_READ: begin
				if (p >= n) r.stat = STAT_RANGE;
				else r.word = shadow_list[p];
			end
			REQ_WRITE: begin
				if (p >= n) r.stat = STAT_RANGE;
				else shadow_list[p] = data;
			end
			default: ;
		endcase
		r.count = 7'(shadow_count);
		r.empty = (shadow_count == 0);
		return r;
	endfunction

	// Presents one request, holds it until the transfer and records what it should return.
	task automatic send_request(input logic [2:0] req, input int pos, input int lim,
		input word_t data);
		list_result_t want;
		start <= 1'b1;
		req_type <= req;
		position <= 7'(pos);
		range_end <= 7'(lim);
		data_word <= data;
		do @(posedge clk); while (busy);
		want = apply_request(req, 7'(pos), 7'(lim), data);
		pending_results = {pending_results, want};
		req_tally[req]++;
		if (want.stat == STAT_FULL) full_tally++;
		if (want.stat == STAT_RANGE) range_tally++;
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin : result_check
		list_result_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (read_word !== want.word) begin
					$error("read_word mismatch: expected %h, got %h", want.word, read_word);
					mismatch_count++;
				end
				if (element_count !== want.count) begin
					$error("element_count mismatch: expected %0d, got %0d", want.count,
						element_count);
					mismatch_count++;
				end
				if (is_empty !== want.empty) begin
					$error("is_empty mismatch: expected %b, got %b", want.empty, is_empty);
					mismatch_count++;
				end
				if (status !== want.stat) begin
					$error("status mismatch: expected %0d, got %0d", want.stat, status);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("positional_insert_erase_list test failed");
				$finish;
			end
		end
	end

	function automatic logic [2:0] pick_request(input int mix);
		int w [8];
		int roll;
		int acc;
		int k;
		case (mix)
			MIX_GROW:   w = '{30, 25, 8, 8, 4, 12, 10, 3};
			MIX_SHRINK: w = '{8, 7, 25, 22, 10, 14, 11, 3};
			default:    w = '{16, 14, 14, 14, 8, 16, 15, 3};
		endcase
		roll = $urandom_range(99);
		acc = 0;
		for (k = 0; k < 8; k++) begin
			acc += w[k];
			if (roll < acc) return 3'(k);
		end
		return REQ_UNUSED;
	endfunction

	function automatic int pick_position(input logic [2:0] req, input int n);
		int roll;
		roll = $urandom_range(99);
		if (roll < 8) return $urandom_range(127);
		if (roll < 16) return n;
		if (roll < 20) return $urandom_range(DEPTH);
		if (req == REQ_INSERT) return $urandom_range(n);
		if (n == 0) return 0;
		return $urandom_range(n - 1);
	endfunction

	task automatic test_empty_list();
		send_request(REQ_REMOVE_LAST, 0, 0, '0);
		send_request(REQ_ERASE_ONE, 0, 0, '0);
		send_request(REQ_READ, 0, 0, '0);
		send_request(REQ_WRITE, 0, 0, 32'hDEAD_BEEF);
		send_request(REQ_INSERT, 1, 0, 32'h0BAD_0BAD);
		send_request(REQ_ERASE_RANGE, 0, 0, '0);
		send_request(REQ_ERASE_RANGE, 0, 1, '0);
		send_request(REQ_UNUSED, 127, 127, 32'hFFFF_FFFF);
	endtask

	task automatic test_edit_operations();
		send_request(REQ_INSERT, 0, 0, 32'h0000_0001);
		send_request(REQ_APPEND, 0, 0, 32'hFFFF_FFFF);
		send_request(REQ_APPEND, 0, 0, 32'h0000_0000);
		send_request(REQ_INSERT, 1, 0, 32'hA5A5_5A5A);
		send_request(REQ_INSERT, 4, 0, 32'h8000_0000);
		send_request(REQ_READ, 0, 0, '0);
		send_request(REQ_READ, 1, 0, '0);
		send_request(REQ_READ, 4, 0, '0);
		send_request(REQ_WRITE, 2, 0, 32'h1234_5678);
		send_request(REQ_READ, 2, 0, '0);
		send_request(REQ_ERASE_ONE, 0, 0, '0);
		send_request(REQ_ERASE_RANGE, 1, 3, '0);
		send_request(REQ_ERASE_RANGE, 2, 1, '0);
		send_request(REQ_ERASE_RANGE, 0, shadow_count + 1, '0);
		send_request(REQ_ERASE_RANGE, 1, 1, '0);
		send_request(REQ_READ, 127, 0, '0);
		send_request(REQ_WRITE, shadow_count, 0, 32'h5555_AAAA);
		send_request(REQ_READ, 1, 0, '0);
		send_request(REQ_REMOVE_LAST, 0, 127, '0);
	endtask

	// Empties the list, fills it to capacity, probes full and out-of-range refusals there, then clears it in one range.
	task automatic test_capacity();
		send_request(REQ_ERASE_RANGE, 0, shadow_count, '0);
		while (shadow_count < DEPTH) send_request(REQ_APPEND, 0, 0, $urandom);
		send_request(REQ_APPEND, 0, 0, 32'hCAFE_F00D);
		send_request(REQ_INSERT, 3, 0, 32'hCAFE_F00D);
		send_request(REQ_INSERT, DEPTH, 0, 32'hCAFE_F00D);
		send_request(REQ_INSERT, DEPTH + 1, 0, 32'hCAFE_F00D);
		send_request(REQ_WRITE, DEPTH - 1, 0, 32'hFFFF_FFFF);
		send_request(REQ_READ, DEPTH - 1, 0, '0);
		send_request(REQ_READ, DEPTH, 0, '0);
		send_request(REQ_ERASE_RANGE, 0, DEPTH, '0);
		send_request(REQ_READ, 0, 0, '0);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int count);
		int mix;
		int k;
		int n;
		int p;
		int e;
		int span;
		int roll;
		logic [2:0] req;
		word_t data;
		sender_idle_pct = idle_pct;
		mix = MIX_EVEN;
		for (k = 0; k < count; k++) begin
			if (k % 50 == 0) mix = $urandom_range(MIX_EVEN);
			req = pick_request(mix);
			n = shadow_count;
			if (req == REQ_ERASE_RANGE) begin
				if ($urandom_range(99) < 15) begin
					p = $urandom_range(DEPTH);
					e = $urandom_range(127);
				end else begin
					p = $urandom_range(n);
					span = n - p;
					if ($urandom_range(99) < 80 && span > 4) span = 4;
					e = p + $urandom_range(span);
				end
			end else begin
				p = pick_position(req, n);
				e = $urandom_range(127);
			end
			roll = $urandom_range(9);
			if (roll == 0) data = '0;
			else if (roll == 1) data = '1;
			else data = $urandom;
			send_request(req, p, e, data);
		end
	endtask

	initial begin
		mismatch_count = 0;
		results_seen = 0;
		stall_cycles = 0;
		sender_idle_pct = 0;
		full_tally = 0;
		range_tally = 0;
		shadow_count = 0;
		foreach (req_tally[k]) req_tally[k] = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		req_type <= REQ_APPEND;
		position <= '0;
		range_end <= '0;
		data_word <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_edit_operations();
		test_capacity();
		test_random_traffic(0, 370);
		test_random_traffic(60, 370);
		test_random_traffic(34, 370);
		test_random_traffic(0, 370);

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d appends, %0d removals, %0d inserts, %0d single erases, %0d range erases,",
			req_tally[REQ_APPEND], req_tally[REQ_REMOVE_LAST], req_tally[REQ_INSERT],
			req_tally[REQ_ERASE_ONE], req_tally[REQ_ERASE_RANGE]);
		$display("%0d reads, %0d writes, %0d unused codes; %0d refused full, %0d out of range; %0d results.",
			req_tally[REQ_READ], req_tally[REQ_WRITE], req_tally[REQ_UNUSED], full_tally,
			range_tally, results_seen);
		if (mismatch_count == 0) begin
			$display("positional_insert_erase_list test passed");
		end else begin
			$display("positional_insert_erase_list test failed");
		end
		$finish;
	end

endmodule
